/* hdl/hist_eq_pkg.sv */
package hist_eq_pkg;

    localparam int unsigned NUM_BINS = 256;
    localparam int unsigned PIX_W    = 8;
    localparam int unsigned CNT_W    = 23;
    localparam int unsigned LIMIT_W  = 25;
    localparam int unsigned DIV_W    = CNT_W + PIX_W;      // cum * 255 + N/2 fits here
    localparam int unsigned DSR_W    = CNT_W + PIX_W - 1;  // N shifted up by seven
    localparam int unsigned STEP_W   = 3;

    localparam logic [LIMIT_W-1:0] MAX_PIXELS = 25'd4194304;
    localparam logic [CNT_W-1:0]   COUNT_MAX  = 23'h7FFFFF;
    localparam logic [PIX_W-1:0]   LAST_BIN   = 8'hFF;
    localparam logic [STEP_W-1:0]  LAST_STEP  = 3'd0;
    localparam logic [STEP_W-1:0]  FIRST_STEP = 3'd7;

    typedef enum logic [1:0] {
        KIND_COUNT  = 2'd0,
        KIND_MAP    = 2'd1,
        KIND_FINISH = 2'd2
    } kind_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CNT_WR,
        S_MAP_OUT,
        S_FIN_RD,
        S_FIN_ACC,
        S_FIN_SCALE,
        S_FIN_DIV,
        S_FIN_WR
    } state_t;

endpackage

/* hdl/gray_histogram_equalizer_top.sv */
// Count items: bin read, then bin write; the block is ready again after that.
// Map items: map read at accept, then output register; a stalled output holds the map item.
// Finish items: every one of the 256 bins is read, accumulated, scaled, divided and written;
// the shared compare-subtract unit forms one quotient bit per cycle for each table entry.
// Reset (rst_n low, asynchronous) clears histogram, total and map table at once through
// per-bin valid bits and a table-built flag; no clearing pass is needed.
module gray_histogram_equalizer_top #(
    parameter logic [hist_eq_pkg::LIMIT_W-1:0] MAX_PIXELS = hist_eq_pkg::MAX_PIXELS
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] pixel
    input  logic [1:0] s_axis_tuser,   // [1:0] kind
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata    // [7:0] mapped_pixel
);

    localparam int unsigned PW = hist_eq_pkg::PIX_W;
    localparam int unsigned CW = hist_eq_pkg::CNT_W;
    localparam int unsigned DW = hist_eq_pkg::DIV_W;
    localparam int unsigned SW = hist_eq_pkg::DSR_W;

    hist_eq_pkg::state_t state_reg, state_next;

    logic [CW-1:0] bin_mem [hist_eq_pkg::NUM_BINS];
    logic [PW-1:0] map_mem [hist_eq_pkg::NUM_BINS];
    logic [hist_eq_pkg::NUM_BINS-1:0] bin_vld_reg, bin_vld_next;

    logic [CW-1:0] bin_q_reg;
    logic          bin_qv_reg;
    logic [PW-1:0] map_q_reg;
    logic          map_built_reg, map_built_next;

    logic [PW-1:0] rd_addr;
    logic [CW-1:0] bin_val;

    logic [PW-1:0] pix_reg, pix_next;
    logic [PW-1:0] idx_reg, idx_next;
    logic [CW-1:0] total_reg, total_next;
    logic [CW-1:0] cum_reg, cum_next;
    logic [DW-1:0] rem_reg, rem_next;
    logic [SW-1:0] dsr_reg, dsr_next;
    logic [PW-1:0] quo_reg, quo_next;
    logic [hist_eq_pkg::STEP_W-1:0] step_reg, step_next;

    logic          out_vld_reg, out_vld_next;
    logic [PW-1:0] out_data_reg, out_data_next;

    logic          in_fire;
    logic          can_count;
    logic          bin_we;
    logic          map_we;
    logic [PW-1:0] map_wdata;
    logic [DW-1:0] div_diff;
    logic          div_ge;

    assign s_axis_tready = (state_reg == hist_eq_pkg::S_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = out_data_reg;

    assign can_count = ({2'b00, total_reg} < MAX_PIXELS)
                    && (total_reg != hist_eq_pkg::COUNT_MAX);

    // keep reading the held pixel while a map result waits for the output register
    assign rd_addr = (state_reg == hist_eq_pkg::S_IDLE)    ? s_axis_tdata :
                     (state_reg == hist_eq_pkg::S_MAP_OUT) ? pix_reg      : idx_reg;
    assign bin_val = bin_qv_reg ? bin_q_reg : '0;

    // shared compare-subtract unit of the divider
    assign div_diff = rem_reg - {1'b0, dsr_reg};
    assign div_ge   = (rem_reg >= {1'b0, dsr_reg});

    assign map_wdata = (total_reg == '0) ? '0 : quo_reg;

    always_ff @(posedge clk)
    begin
        bin_q_reg <= bin_mem[rd_addr];
        map_q_reg <= map_mem[rd_addr];
        if (bin_we)
        begin
            bin_mem[pix_reg] <= bin_val + 1'b1;
        end
        if (map_we)
        begin
            map_mem[idx_reg] <= map_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= hist_eq_pkg::S_IDLE;
            bin_vld_reg   <= '0;
            bin_qv_reg    <= 1'b0;
            map_built_reg <= 1'b0;
            total_reg     <= '0;
            out_vld_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            bin_vld_reg   <= bin_vld_next;
            bin_qv_reg    <= bin_vld_reg[rd_addr];
            map_built_reg <= map_built_next;
            total_reg     <= total_next;
            out_vld_reg   <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pix_reg      <= pix_next;
        idx_reg      <= idx_next;
        cum_reg      <= cum_next;
        rem_reg      <= rem_next;
        dsr_reg      <= dsr_next;
        quo_reg      <= quo_next;
        step_reg     <= step_next;
        out_data_reg <= out_data_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        bin_vld_next   = bin_vld_reg;
        map_built_next = map_built_reg;
        total_next     = total_reg;
        pix_next       = pix_reg;
        idx_next       = idx_reg;
        cum_next       = cum_reg;
        rem_next       = rem_reg;
        dsr_next       = dsr_reg;
        quo_next       = quo_reg;
        step_next      = step_reg;
        out_data_next  = out_data_reg;
        out_vld_next   = out_vld_reg && !m_axis_tready;
        bin_we         = 1'b0;
        map_we         = 1'b0;

        unique case (state_reg)
            hist_eq_pkg::S_IDLE:
            begin
                pix_next = s_axis_tdata;
                if (in_fire)
                begin
                    unique case (hist_eq_pkg::kind_t'(s_axis_tuser))
                        hist_eq_pkg::KIND_COUNT:
                        begin
                            if (can_count)
                            begin
                                state_next = hist_eq_pkg::S_CNT_WR;
                            end
                        end
                        hist_eq_pkg::KIND_MAP:
                        begin
                            state_next = hist_eq_pkg::S_MAP_OUT;
                        end
                        hist_eq_pkg::KIND_FINISH:
                        begin
                            idx_next   = '0;
                            cum_next   = '0;
                            state_next = hist_eq_pkg::S_FIN_RD;
                        end
                        default:
                        begin
                            // drop unused kind
                            state_next = hist_eq_pkg::S_IDLE;
                        end
                    endcase
                end
            end
            hist_eq_pkg::S_CNT_WR:
            begin
                bin_we                = 1'b1;
                bin_vld_next[pix_reg] = 1'b1;
                total_next            = total_reg + 1'b1;
                state_next            = hist_eq_pkg::S_IDLE;
            end
            hist_eq_pkg::S_MAP_OUT:
            begin
                // hold until the output register is free
                if (!out_vld_reg || m_axis_tready)
                begin
                    out_vld_next  = 1'b1;
                    out_data_next = map_built_reg ? map_q_reg : '0;
                    state_next    = hist_eq_pkg::S_IDLE;
                end
            end
            hist_eq_pkg::S_FIN_RD:
            begin
                state_next = hist_eq_pkg::S_FIN_ACC;
            end
            hist_eq_pkg::S_FIN_ACC:
            begin
                cum_next              = cum_reg + bin_val;
                bin_vld_next[idx_reg] = 1'b0;
                state_next            = hist_eq_pkg::S_FIN_SCALE;
            end
            hist_eq_pkg::S_FIN_SCALE:
            begin
                rem_next   = {cum_reg, {PW{1'b0}}} - {{PW{1'b0}}, cum_reg}
                           + {{(PW+1){1'b0}}, total_reg[CW-1:1]};
                dsr_next   = {total_reg, {(SW-CW){1'b0}}};
                quo_next   = '0;
                step_next  = hist_eq_pkg::FIRST_STEP;
                state_next = hist_eq_pkg::S_FIN_DIV;
            end
            hist_eq_pkg::S_FIN_DIV:
            begin
                quo_next = {quo_reg[PW-2:0], div_ge};
                if (div_ge)
                begin
                    rem_next = div_diff;
                end
                dsr_next  = {1'b0, dsr_reg[SW-1:1]};
                step_next = step_reg - 1'b1;
                if (step_reg == hist_eq_pkg::LAST_STEP)
                begin
                    state_next = hist_eq_pkg::S_FIN_WR;
                end
            end
            hist_eq_pkg::S_FIN_WR:
            begin
                map_we = 1'b1;
                if (idx_reg == hist_eq_pkg::LAST_BIN)
                begin
                    total_next     = '0;
                    map_built_next = 1'b1;
                    state_next     = hist_eq_pkg::S_IDLE;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = hist_eq_pkg::S_FIN_RD;
                end
            end
            default:
            begin
                state_next = hist_eq_pkg::S_IDLE;
            end
        endcase
    end

    a_total_limit: assert property (@(posedge clk) disable iff (!rst_n)
        {2'b00, total_reg} <= MAX_PIXELS)
        else $error("pixel total beyond limit");

    a_cum_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == hist_eq_pkg::S_FIN_SCALE) |-> (cum_reg <= total_reg))
        else $error("running sum exceeds pixel total");

    a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == hist_eq_pkg::S_FIN_WR && total_reg != '0)
            |-> (rem_reg < {{PW{1'b0}}, total_reg}))
        else $error("divider remainder not below divisor");

    a_fin_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == hist_eq_pkg::S_FIN_WR && idx_reg == hist_eq_pkg::LAST_BIN)
            |=> (total_reg == '0 && bin_vld_reg == '0 && map_built_reg))
        else $error("histogram not cleared after rebuild");

    a_map_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == hist_eq_pkg::S_MAP_OUT && (!out_vld_reg || m_axis_tready))
            |=> (out_vld_reg && state_reg == hist_eq_pkg::S_IDLE))
        else $error("map result not loaded");

endmodule
